// File: src/zpd_pkg.sv
`default_nettype none
package zpd_pkg;

  localparam int MAX_ZONES   = 64;
  localparam int SMALL_ZONES = 16;
  localparam int POS_W       = $clog2(MAX_ZONES);
  localparam int CNT_W       = $clog2(MAX_ZONES + 1);
  localparam int STATUS_W    = 8;
  localparam int DIST_W      = 16;
  localparam int TIME_W      = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [STATUS_W-1:0] STATUS_VALID_A = STATUS_W'(5);
  localparam logic [STATUS_W-1:0] STATUS_VALID_B = STATUS_W'(9);

  localparam logic [POS_W-1:0] LAST_LARGE = POS_W'(MAX_ZONES - 1);
  localparam logic [POS_W-1:0] LAST_SMALL = POS_W'(SMALL_ZONES - 1);

  localparam logic [DIST_W-1:0] DIST_FAR = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_IS_LARGE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ZONES     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_OCCUPY_DELAY  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_VACATE_DELAY  = CFG_IDX_W'(5);

  localparam logic [DIST_W-1:0] RST_WINDOW_LOW   = DIST_W'(100);
  localparam logic [DIST_W-1:0] RST_WINDOW_HIGH  = DIST_W'(1200);
  localparam logic [CNT_W-1:0]  RST_MIN_ZONES    = CNT_W'(4);
  localparam logic [TIME_W-1:0] RST_OCCUPY_DELAY = TIME_W'(5000);
  localparam logic [TIME_W-1:0] RST_VACATE_DELAY = TIME_W'(60000);

  typedef struct packed {
    logic              grid_is_large;
    logic [DIST_W-1:0] window_low_mm;
    logic [DIST_W-1:0] window_high_mm;
    logic [CNT_W-1:0]  min_zones;
    logic [TIME_W-1:0] occupy_delay_ms;
    logic [TIME_W-1:0] vacate_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] zone_status;
    logic [DIST_W-1:0]   zone_distance_mm;
    logic [TIME_W-1:0]   now_ms;
  } zone_item_t;

  typedef struct packed {
    logic              last;
    logic [CNT_W-1:0]  valid_cnt;
    logic [CNT_W-1:0]  in_window_cnt;
    logic [DIST_W-1:0] nearest;
  } frame_sum_t;

endpackage
`default_nettype wire

// File: src/zpd_cfg.sv
`default_nettype none
module zpd_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [zpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [zpd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output zpd_pkg::cfg_t                         cfg
);

  zpd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_is_large   <= 1'b0;
      cfg_r.window_low_mm   <= zpd_pkg::RST_WINDOW_LOW;
      cfg_r.window_high_mm  <= zpd_pkg::RST_WINDOW_HIGH;
      cfg_r.min_zones       <= zpd_pkg::RST_MIN_ZONES;
      cfg_r.occupy_delay_ms <= zpd_pkg::RST_OCCUPY_DELAY;
      cfg_r.vacate_delay_ms <= zpd_pkg::RST_VACATE_DELAY;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        zpd_pkg::CFG_GRID_IS_LARGE: cfg_r.grid_is_large   <= cfg_wdata[0];
        zpd_pkg::CFG_WINDOW_LOW:    cfg_r.window_low_mm   <= cfg_wdata[zpd_pkg::DIST_W-1:0];
        zpd_pkg::CFG_WINDOW_HIGH:   cfg_r.window_high_mm  <= cfg_wdata[zpd_pkg::DIST_W-1:0];
        zpd_pkg::CFG_MIN_ZONES:     cfg_r.min_zones       <= cfg_wdata[zpd_pkg::CNT_W-1:0];
        zpd_pkg::CFG_OCCUPY_DELAY:  cfg_r.occupy_delay_ms <= cfg_wdata[zpd_pkg::TIME_W-1:0];
        zpd_pkg::CFG_VACATE_DELAY:  cfg_r.vacate_delay_ms <= cfg_wdata[zpd_pkg::TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// File: src/zpd_in_stage.sv
`default_nettype none
module zpd_in_stage (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [zpd_pkg::STATUS_W-1:0]   in_zone_status,
  input  wire logic [zpd_pkg::DIST_W-1:0]     in_zone_distance_mm,
  input  wire logic [zpd_pkg::TIME_W-1:0]     in_now_ms,
  input  wire logic                           s1_go,
  output logic                                s1_valid,
  output zpd_pkg::zone_item_t                 s1_item
);

  logic                s1_valid_r;
  zpd_pkg::zone_item_t s1_item_r;
  logic                accept;

  assign in_stall = s1_valid_r && !s1_go;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r.zone_status      <= in_zone_status;
      s1_item_r.zone_distance_mm <= in_zone_distance_mm;
      s1_item_r.now_ms           <= in_now_ms;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule
`default_nettype wire

// File: src/zpd_frame.sv
`default_nettype none
module zpd_frame (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire zpd_pkg::cfg_t cfg,
  input  wire zpd_pkg::zone_item_t s1_item,
  input  wire logic          s1_go,
  output zpd_pkg::frame_sum_t sum
);

  logic [zpd_pkg::POS_W-1:0]  pos_r;
  logic [zpd_pkg::DIST_W-1:0] nearest_r;
  logic [zpd_pkg::CNT_W-1:0]  valid_cnt_r;
  logic [zpd_pkg::CNT_W-1:0]  in_win_cnt_r;

  logic [zpd_pkg::POS_W-1:0]  last_pos;
  logic                       zone_ok;
  logic                       in_window;
  logic [zpd_pkg::DIST_W-1:0] nearest_nxt;
  logic [zpd_pkg::CNT_W-1:0]  valid_cnt_nxt;
  logic [zpd_pkg::CNT_W-1:0]  in_win_cnt_nxt;
  logic                       is_last;

  assign last_pos = cfg.grid_is_large ? zpd_pkg::LAST_LARGE : zpd_pkg::LAST_SMALL;
  assign is_last  = !(pos_r < last_pos);

  assign zone_ok = (s1_item.zone_status == zpd_pkg::STATUS_VALID_A) ||
                   (s1_item.zone_status == zpd_pkg::STATUS_VALID_B);
  assign in_window = (s1_item.zone_distance_mm >= cfg.window_low_mm) &&
                     (s1_item.zone_distance_mm <= cfg.window_high_mm);

  always_comb begin
    nearest_nxt    = nearest_r;
    valid_cnt_nxt  = valid_cnt_r;
    in_win_cnt_nxt = in_win_cnt_r;
    if (zone_ok) begin
      valid_cnt_nxt = valid_cnt_r + zpd_pkg::CNT_W'(1);
      if (s1_item.zone_distance_mm < nearest_r) begin
        nearest_nxt = s1_item.zone_distance_mm;
      end
      if (in_window) begin
        in_win_cnt_nxt = in_win_cnt_r + zpd_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      nearest_r    <= zpd_pkg::DIST_FAR;
      valid_cnt_r  <= '0;
      in_win_cnt_r <= '0;
    end else if (s1_go) begin
      if (is_last) begin
        pos_r        <= '0;
        nearest_r    <= zpd_pkg::DIST_FAR;
        valid_cnt_r  <= '0;
        in_win_cnt_r <= '0;
      end else begin
        pos_r        <= pos_r + zpd_pkg::POS_W'(1);
        nearest_r    <= nearest_nxt;
        valid_cnt_r  <= valid_cnt_nxt;
        in_win_cnt_r <= in_win_cnt_nxt;
      end
    end
  end

  assign sum.last          = is_last;
  assign sum.valid_cnt     = valid_cnt_nxt;
  assign sum.in_window_cnt = in_win_cnt_nxt;
  assign sum.nearest       = nearest_nxt;

endmodule
`default_nettype wire

// File: src/zpd_debounce.sv
`default_nettype none
module zpd_debounce (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire zpd_pkg::cfg_t               cfg,
  input  wire zpd_pkg::frame_sum_t         sum,
  input  wire logic [zpd_pkg::TIME_W-1:0]  now_ms,
  input  wire logic                        frame_done,
  output logic                             out_free,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_occupied,
  output logic                             out_changed,
  output logic                             out_presence,
  output logic [zpd_pkg::DIST_W-1:0]       out_nearest_mm,
  output logic [zpd_pkg::CNT_W-1:0]        out_in_window_zones,
  output logic [zpd_pkg::CNT_W-1:0]        out_valid_zones
);

  logic                       occ_r;
  logic [zpd_pkg::TIME_W-1:0] pres_start_r;
  logic [zpd_pkg::TIME_W-1:0] abs_start_r;
  logic [zpd_pkg::DIST_W-1:0] rep_dist_r;

  logic                       out_valid_r;
  logic                       out_occ_r;
  logic                       out_chg_r;
  logic                       out_pres_r;
  logic [zpd_pkg::DIST_W-1:0] out_dist_r;
  logic [zpd_pkg::CNT_W-1:0]  out_inwin_r;
  logic [zpd_pkg::CNT_W-1:0]  out_vcnt_r;

  logic                       presence;
  logic [zpd_pkg::TIME_W-1:0] start_cur;
  logic [zpd_pkg::TIME_W-1:0] start_eff;
  logic [zpd_pkg::TIME_W-1:0] elapsed;
  logic [zpd_pkg::TIME_W-1:0] delay;
  logic                       flip;
  logic                       occ_nxt;
  logic [zpd_pkg::DIST_W-1:0] rep_dist_nxt;

  assign out_free = !out_valid_r || !out_stall;

  assign presence  = sum.in_window_cnt >= cfg.min_zones;
  assign start_cur = presence ? pres_start_r : abs_start_r;
  assign start_eff = (start_cur == '0) ? now_ms : start_cur;
  assign elapsed   = now_ms - start_eff;
  assign delay     = presence ? cfg.occupy_delay_ms : cfg.vacate_delay_ms;
  // presence can only set, absence can only clear
  assign flip      = (presence != occ_r) && (elapsed >= delay);
  assign occ_nxt   = flip ? presence : occ_r;
  assign rep_dist_nxt = (sum.valid_cnt != '0) ? sum.nearest : rep_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r        <= 1'b0;
      pres_start_r <= '0;
      abs_start_r  <= '0;
      rep_dist_r   <= '0;
    end else if (frame_done) begin
      occ_r      <= occ_nxt;
      rep_dist_r <= rep_dist_nxt;
      if (presence) begin
        abs_start_r  <= '0;
        pres_start_r <= start_eff;
      end else begin
        pres_start_r <= '0;
        abs_start_r  <= start_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (frame_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      out_occ_r   <= occ_nxt;
      out_chg_r   <= flip;
      out_pres_r  <= presence;
      out_dist_r  <= rep_dist_nxt;
      out_inwin_r <= sum.in_window_cnt;
      out_vcnt_r  <= sum.valid_cnt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_occupied        = out_occ_r;
  assign out_changed         = out_chg_r;
  assign out_presence        = out_pres_r;
  assign out_nearest_mm      = out_dist_r;
  assign out_in_window_zones = out_inwin_r;
  assign out_valid_zones     = out_vcnt_r;

endmodule
`default_nettype wire

// File: src/zone_presence_debouncer_top.sv
`default_nettype none
// Zone presence debouncer. Takes one zone reading per item, 16 or 64 zones
// per frame as set by grid_is_large, and emits one result on the last zone
// of each frame: raw presence (in-window valid zones >= min_zones), the
// debounced occupied flag, a changed flag, the nearest valid distance and
// the zone counts. Throughput is one item per clock while no last zone
// waits for room in the output register; an item passes an input register
// and the frame counters; a frame result enters the output register on the
// same edge as its last zone leaves the input register. The user must write
// configuration only while no item is in flight; it is not enforced.
module zone_presence_debouncer_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [zpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [zpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [zpd_pkg::STATUS_W-1:0]    in_zone_status,
  input  wire logic [zpd_pkg::DIST_W-1:0]      in_zone_distance_mm,
  input  wire logic [zpd_pkg::TIME_W-1:0]      in_now_ms,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_occupied,
  output logic                                 out_changed,
  output logic                                 out_presence,
  output logic [zpd_pkg::DIST_W-1:0]           out_nearest_mm,
  output logic [zpd_pkg::CNT_W-1:0]            out_in_window_zones,
  output logic [zpd_pkg::CNT_W-1:0]            out_valid_zones
);

  zpd_pkg::cfg_t       cfg;
  zpd_pkg::zone_item_t s1_item;
  zpd_pkg::frame_sum_t sum;
  logic                s1_valid;
  logic                s1_go;
  logic                out_free;
  logic                frame_done;

  // a last zone waits for room in the output register
  assign s1_go      = s1_valid && (!sum.last || out_free);
  assign frame_done = s1_go && sum.last;

  zpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  zpd_in_stage u_in (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_zone_status      (in_zone_status),
    .in_zone_distance_mm (in_zone_distance_mm),
    .in_now_ms           (in_now_ms),
    .s1_go               (s1_go),
    .s1_valid            (s1_valid),
    .s1_item             (s1_item)
  );

  zpd_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .s1_item (s1_item),
    .s1_go   (s1_go),
    .sum     (sum)
  );

  zpd_debounce u_deb (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .sum                 (sum),
    .now_ms              (s1_item.now_ms),
    .frame_done          (frame_done),
    .out_free            (out_free),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_occupied        (out_occupied),
    .out_changed         (out_changed),
    .out_presence        (out_presence),
    .out_nearest_mm      (out_nearest_mm),
    .out_in_window_zones (out_in_window_zones),
    .out_valid_zones     (out_valid_zones)
  );

endmodule
`default_nettype wire

// File: src/zpd_checker.sv
`default_nettype none
module zpd_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic                        out_occupied,
  input wire logic                        out_changed,
  input wire logic                        out_presence,
  input wire logic [zpd_pkg::DIST_W-1:0]  out_nearest_mm,
  input wire logic [zpd_pkg::CNT_W-1:0]   out_in_window_zones,
  input wire logic [zpd_pkg::CNT_W-1:0]   out_valid_zones
);

  logic last_occ_r;

  // occupancy as last delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_occ_r <= 1'b0;
    end else if (out_valid && !out_stall) begin
      last_occ_r <= out_occupied;
    end
  end

  a_changed_tracks_flip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |-> (out_changed == (out_occupied != last_occ_r)))
    else $error("changed does not match occupancy flip");

  a_flip_follows_presence: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_changed |-> (out_occupied == out_presence))
    else $error("occupancy flipped against raw presence");

  a_window_within_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_in_window_zones <= out_valid_zones) &&
                  (out_valid_zones <= zpd_pkg::CNT_W'(zpd_pkg::MAX_ZONES)))
    else $error("zone counts out of range");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_occupied) &&
      $stable(out_changed) && $stable(out_presence) && $stable(out_nearest_mm) &&
      $stable(out_in_window_zones) && $stable(out_valid_zones))
    else $error("stalled result changed");

endmodule

bind zone_presence_debouncer_top zpd_checker u_zpd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_occupied        (out_occupied),
  .out_changed         (out_changed),
  .out_presence        (out_presence),
  .out_nearest_mm      (out_nearest_mm),
  .out_in_window_zones (out_in_window_zones),
  .out_valid_zones     (out_valid_zones)
);
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
module tb;
  import zpd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic              occupied;
    logic              changed;
    logic              presence;
    logic [DIST_W-1:0] nearest_mm;
    logic [CNT_W-1:0]  in_window_zones;
    logic [CNT_W-1:0]  valid_zones;
  } frame_result_t;

  typedef enum int {
    SCENE_FULL,
    SCENE_BUSY,
    SCENE_MIXED,
    SCENE_FAR,
    SCENE_EMPTY,
    SCENE_LONE_FAR
  } scene_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [STATUS_W-1:0]   in_zone_status = '0;
  logic [DIST_W-1:0]     in_zone_distance_mm = '0;
  logic [TIME_W-1:0]     in_now_ms = '0;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_occupied;
  logic                  out_changed;
  logic                  out_presence;
  logic [DIST_W-1:0]     out_nearest_mm;
  logic [CNT_W-1:0]      out_in_window_zones;
  logic [CNT_W-1:0]      out_valid_zones;

  zone_presence_debouncer_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_zone_status      (in_zone_status),
    .in_zone_distance_mm (in_zone_distance_mm),
    .in_now_ms           (in_now_ms),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_occupied        (out_occupied),
    .out_changed         (out_changed),
    .out_presence        (out_presence),
    .out_nearest_mm      (out_nearest_mm),
    .out_in_window_zones (out_in_window_zones),
    .out_valid_zones     (out_valid_zones)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  cfg_t              cfg_model;
  logic              occ_q;
  logic [TIME_W-1:0] present_since;
  logic [TIME_W-1:0] absent_since;
  logic [DIST_W-1:0] shown_dist;
  logic [POS_W-1:0]  zone_pos;
  logic [DIST_W-1:0] frame_near;
  logic [CNT_W-1:0]  frame_in_win;
  logic [CNT_W-1:0]  frame_valid_cnt;

  frame_result_t expected_frames[$];

  int errors = 0;
  int zones_sent = 0;
  int frames_checked = 0;
  int flips_expected = 0;
  int settings_used = 0;
  int quiet_cycles = 0;
  int src_gap_max = 0;
  int sink_gap_max = 0;
  int time_step_max = 1000;
  logic [TIME_W-1:0] clock_ms = '0;

  function automatic logic [POS_W-1:0] last_zone();
    return cfg_model.grid_is_large ? LAST_LARGE : LAST_SMALL;
  endfunction

  function automatic bit is_frame_end();
    return zone_pos >= last_zone();
  endfunction

  function automatic void clear_frame_model();
    zone_pos        = '0;
    frame_near      = DIST_FAR;
    frame_in_win    = '0;
    frame_valid_cnt = '0;
  endfunction

  function automatic void predict_zone(input logic [STATUS_W-1:0] status,
                                       input logic [DIST_W-1:0] distance,
                                       input logic [TIME_W-1:0] now);
    frame_result_t     r;
    logic [TIME_W-1:0] elapsed;
    if (status == STATUS_VALID_A || status == STATUS_VALID_B) begin
      frame_valid_cnt = frame_valid_cnt + 1'b1;
      if (distance < frame_near) frame_near = distance;
      if (distance >= cfg_model.window_low_mm && distance <= cfg_model.window_high_mm)
        frame_in_win = frame_in_win + 1'b1;
    end
    if (zone_pos < last_zone()) begin
      zone_pos = zone_pos + 1'b1;
      return;
    end
    if (frame_valid_cnt != 0) shown_dist = frame_near;
    r.changed  = 1'b0;
    r.presence = frame_in_win >= cfg_model.min_zones;
    if (r.presence) begin
      absent_since = '0;
      if (present_since == 0) present_since = now;
      elapsed = now - present_since;
      if (!occ_q && elapsed >= cfg_model.occupy_delay_ms) begin
        occ_q     = 1'b1;
        r.changed = 1'b1;
      end
    end else begin
      present_since = '0;
      if (absent_since == 0) absent_since = now;
      elapsed = now - absent_since;
      if (occ_q && elapsed >= cfg_model.vacate_delay_ms) begin
        occ_q     = 1'b0;
        r.changed = 1'b1;
      end
    end
    r.occupied        = occ_q;
    r.nearest_mm      = shown_dist;
    r.in_window_zones = frame_in_win;
    r.valid_zones     = frame_valid_cnt;
    expected_frames.push_back(r);
    if (r.changed) flips_expected++;
    clear_frame_model();
  endfunction

  function automatic cfg_t make_cfg(input bit big_grid, input int low, input int high,
                                    input int min_cnt, input logic [TIME_W-1:0] occ,
                                    input logic [TIME_W-1:0] vac);
    cfg_t c;
    c.grid_is_large   = big_grid;
    c.window_low_mm   = DIST_W'(low);
    c.window_high_mm  = DIST_W'(high);
    c.min_zones       = CNT_W'(min_cnt);
    c.occupy_delay_ms = occ;
    c.vacate_delay_ms = vac;
    return c;
  endfunction

  function automatic logic [TIME_W-1:0] next_frame_time();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return '0;
    if (roll < 8) clock_ms = clock_ms + TIME_W'($urandom);
    else clock_ms = clock_ms + TIME_W'($urandom_range(0, time_step_max));
    return clock_ms;
  endfunction

  function automatic logic [DIST_W-1:0] pick_distance(input bit in_window);
    int roll;
    int lo;
    int hi;
    lo   = cfg_model.window_low_mm;
    hi   = cfg_model.window_high_mm;
    roll = $urandom_range(0, 99);
    if (in_window && lo <= hi) begin
      if (roll < 12) return DIST_W'(lo);
      if (roll < 24) return DIST_W'(hi);
      return DIST_W'($urandom_range(lo, hi));
    end
    if (roll < 10) return '0;
    if (roll < 20) return DIST_FAR;
    if (roll < 30) return DIST_W'(lo - 1);
    if (roll < 40) return DIST_W'(hi + 1);
    return DIST_W'($urandom);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  task automatic send_zone(input logic [STATUS_W-1:0] status,
                           input logic [DIST_W-1:0] distance,
                           input logic [TIME_W-1:0] now);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_zone_status      <= status;
    in_zone_distance_mm <= distance;
    in_now_ms           <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_zone(status, distance, now);
    zones_sent++;
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value, input int width);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= (junk << width) | value;
    @(posedge clk);
  endtask

  task automatic apply_cfg(input cfg_t c);
    wait_quiet();
    cfg_write(CFG_GRID_IS_LARGE, CFG_DATA_W'(c.grid_is_large), 1);
    cfg_write(CFG_WINDOW_LOW, CFG_DATA_W'(c.window_low_mm), DIST_W);
    cfg_write(CFG_WINDOW_HIGH, CFG_DATA_W'(c.window_high_mm), DIST_W);
    cfg_write(CFG_MIN_ZONES, CFG_DATA_W'(c.min_zones), CNT_W);
    cfg_write(CFG_OCCUPY_DELAY, c.occupy_delay_ms, TIME_W);
    cfg_write(CFG_VACATE_DELAY, c.vacate_delay_ms, TIME_W);
    cfg_wr_en <= 1'b0;
    cfg_model = c;
    settings_used++;
  endtask

  task automatic send_scene_zone(input scene_e scene);
    int                  p_valid;
    int                  p_in;
    logic [STATUS_W-1:0] st;
    logic [DIST_W-1:0]   d;
    logic [TIME_W-1:0]   t;
    case (scene)
      SCENE_FULL: begin
        p_valid = 100; p_in = 100;
      end
      SCENE_BUSY: begin
        p_valid = 85; p_in = 85;
      end
      SCENE_MIXED: begin
        p_valid = 50; p_in = 40;
      end
      SCENE_FAR: begin
        p_valid = 80; p_in = 5;
      end
      SCENE_EMPTY: begin
        p_valid = 0; p_in = 0;
      end
      default: begin
        p_valid = 6; p_in = 0;
      end
    endcase
    if ($urandom_range(0, 99) < p_valid) begin
      st = $urandom_range(0, 1) ? STATUS_VALID_A : STATUS_VALID_B;
    end else begin
      st = STATUS_W'($urandom);
      while (st == STATUS_VALID_A || st == STATUS_VALID_B) st = STATUS_W'($urandom);
    end
    d = (scene == SCENE_LONE_FAR) ? DIST_FAR : pick_distance($urandom_range(0, 99) < p_in);
    t = is_frame_end() ? next_frame_time() : TIME_W'($urandom);
    send_zone(st, d, t);
  endtask

  // scenes persist for a few frames so the debounce timers can expire
  task automatic run_scenes(input int n_items);
    scene_e scene;
    int     frames_left;
    bit     ending;
    scene       = scene_e'($urandom_range(0, 5));
    frames_left = $urandom_range(1, 6);
    repeat (n_items) begin
      ending = is_frame_end();
      send_scene_zone(scene);
      if (ending) begin
        frames_left--;
        if (frames_left == 0) begin
          scene       = scene_e'($urandom_range(0, 5));
          frames_left = $urandom_range(1, 6);
        end
      end
    end
  endtask

  task automatic test_reset_defaults();
    src_gap_max   = 0;
    sink_gap_max  = 0;
    time_step_max = 2000;
    clock_ms      = 32'd1000;
    run_scenes(48);
  endtask

  task automatic test_directed_extremes();
    logic [STATUS_W-1:0] st_list [18];
    logic [DIST_W-1:0]   d_list [18];
    cfg_t                c;
    src_gap_max  = 12;
    sink_gap_max = 12;
    c = make_cfg(1, 100, 1200, 2, 0, 0);
    apply_cfg(c);
    st_list = '{STATUS_VALID_A, STATUS_VALID_B, 8'd0, 8'hFF,
                STATUS_VALID_A - 8'd1, STATUS_VALID_A + 8'd1,
                STATUS_VALID_B - 8'd1, STATUS_VALID_B + 8'd1, 8'd13,
                STATUS_VALID_A, STATUS_VALID_B, STATUS_VALID_A, STATUS_VALID_B,
                8'd1, STATUS_VALID_A, STATUS_VALID_B, STATUS_VALID_A, STATUS_VALID_B};
    d_list  = '{16'd0, DIST_FAR, 16'd100, 16'd150, 16'd500, 16'd500, 16'd500, 16'd500,
                16'd500, 16'd100, 16'd1200, 16'd99, 16'd1201, 16'd700, 16'd700,
                DIST_FAR, 16'd1000, 16'd200};
    for (int i = 0; i < 18; i++)
      send_zone(st_list[i], d_list[i], i[0] ? '1 : '0);
    // shrink the grid with 18 zones already taken: the next zone closes the frame
    c.grid_is_large = 1'b0;
    apply_cfg(c);
    send_zone(STATUS_VALID_B, 16'd300, '0);
  endtask

  task automatic test_steady_small_grid();
    src_gap_max   = 12;
    sink_gap_max  = 12;
    time_step_max = 1000;
    apply_cfg(make_cfg(0, 100, 1200, 4, 2000, 3000));
    run_scenes(128);
  endtask

  task automatic test_large_grid();
    src_gap_max   = 0;
    sink_gap_max  = 12;
    time_step_max = 800;
    apply_cfg(make_cfg(1, 300, 2500, 20, 1500, 2500));
    run_scenes(128);
    src_gap_max  = 12;
    sink_gap_max = 0;
    apply_cfg(make_cfg(1, 0, 65535, 64, 0, 100));
    run_scenes(128);
  endtask

  task automatic test_window_always();
    src_gap_max  = 0;
    sink_gap_max = 0;
    apply_cfg(make_cfg(0, 0, 65535, 0, 0, 0));
    run_scenes(64);
  endtask

  task automatic test_window_never();
    src_gap_max  = 12;
    sink_gap_max = 0;
    apply_cfg(make_cfg(0, 5000, 10, 127, '1, '1));
    run_scenes(64);
    sink_gap_max = 12;
    apply_cfg(make_cfg(0, 0, 65535, 65, 0, 0));
    run_scenes(48);
  endtask

  task automatic test_time_wrap();
    src_gap_max   = 12;
    sink_gap_max  = 12;
    time_step_max = 900;
    clock_ms      = 32'hFFFF_F000;
    apply_cfg(make_cfg(0, 100, 1200, 3, 1500, 2000));
    run_scenes(128);
  endtask

  task automatic test_grid_switch_mid_frame();
    cfg_t c;
    repeat (4) begin
      src_gap_max  = 12 * $urandom_range(0, 1);
      sink_gap_max = 12 * $urandom_range(0, 1);
      run_scenes($urandom_range(1, 40));
      c = cfg_model;
      c.grid_is_large = ~c.grid_is_large;
      apply_cfg(c);
    end
  endtask

  task automatic test_random_settings();
    cfg_t c;
    repeat (2) begin
      c.grid_is_large = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) begin
        c.window_low_mm  = DIST_W'($urandom);
        c.window_high_mm = DIST_W'($urandom);
      end else begin
        c.window_low_mm  = DIST_W'($urandom_range(0, 1500));
        c.window_high_mm = DIST_W'($urandom_range(c.window_low_mm, 6000));
      end
      c.min_zones = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom)
                                                : CNT_W'($urandom_range(0, 12));
      c.occupy_delay_ms = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 4000);
      c.vacate_delay_ms = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 4000);
      time_step_max = $urandom_range(0, 3000);
      src_gap_max   = 12 * $urandom_range(0, 1);
      sink_gap_max  = 12 * $urandom_range(0, 1);
      apply_cfg(c);
      run_scenes(c.grid_is_large ? 128 : 48);
    end
  endtask

  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = $urandom_range(0, sink_gap_max);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(rst_n && out_valid)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $error("frame result with no frame pending");
        errors++;
      end else begin
        want = expected_frames.pop_front();
        check_field("occupied", 32'(want.occupied), 32'(out_occupied));
        check_field("changed", 32'(want.changed), 32'(out_changed));
        check_field("presence", 32'(want.presence), 32'(out_presence));
        check_field("nearest_mm", 32'(want.nearest_mm), 32'(out_nearest_mm));
        check_field("in_window_zones", 32'(want.in_window_zones),
                    32'(out_in_window_zones));
        check_field("valid_zones", 32'(want.valid_zones), 32'(out_valid_zones));
        frames_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    cfg_model = make_cfg(0, RST_WINDOW_LOW, RST_WINDOW_HIGH, RST_MIN_ZONES,
                         RST_OCCUPY_DELAY, RST_VACATE_DELAY);
    occ_q         = 1'b0;
    present_since = '0;
    absent_since  = '0;
    shown_dist    = '0;
    clear_frame_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_extremes();
    test_steady_small_grid();
    test_large_grid();
    test_window_always();
    test_window_never();
    test_time_wrap();
    test_grid_switch_mid_frame();
    test_random_settings();
    wait_quiet();
    $display("checked %0d frames from %0d zone items over %0d register settings",
             frames_checked, zones_sent, settings_used);
    $display("%0d occupancy flips predicted; mid-frame grid changes, window and %s",
             flips_expected, "threshold extremes, timestamp wrap and zero timestamps");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
src/zpd_pkg.sv
src/zpd_cfg.sv
src/zpd_in_stage.sv
src/zpd_frame.sv
src/zpd_debounce.sv
src/zone_presence_debouncer_top.sv
src/zpd_checker.sv
tb/tb.sv
